### hw/rtl/pcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_pkg: shared types, codes and CRC-32 helpers for the PNG chunk framer
// Holds the job record passed from front to back, the result codes and the
// bitwise reflected CRC-32 byte update.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam int LEN_W  = 31;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;

  // Job queue geometry
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Result index within one job (up to twelve results)
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_LEN_END  = 4'd4;
  localparam logic [IDX_W-1:0] IDX_TYPE_END = 4'd8;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST = 4'd7;
  localparam logic [IDX_W-1:0] IDX_HDR_FIN  = 4'd11;
  localparam logic [IDX_W-1:0] IDX_DAT_FIN  = 4'd4;

  // Request codes on the input channel
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_type_t;

  // Kind of each result byte
  typedef enum logic [2:0] {
    KIND_LENGTH = 3'd0,
    KIND_TYPE   = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_CRC    = 3'd3,
    KIND_NONE   = 3'd4
  } byte_kind_t;

  // Error codes on results
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_CHUNK = 2'd1,
    ERR_ABANDON  = 2'd2
  } err_code_t;

  // Work classes handed from front to back
  typedef enum logic [1:0] {
    JOB_ERR  = 2'd0,
    JOB_HDR  = 2'd1,
    JOB_DATA = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    err_code_t         err;
    logic              fin;    // chunk closes after this job: emit CRC
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] ctype;
    logic [BYTE_W-1:0] data;
    logic [WORD_W-1:0] crc;    // final, already inverted
  } job_t;

  // Reflected CRC-32 update over one byte, one bit per step
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // CRC-32 update over a word, most significant byte first
  function automatic logic [31:0] crc_word(input logic [31:0] c_in,
                                           input logic [31:0] w);
    logic [31:0] c;
    c = crc_byte(c_in, w[31:24]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[7:0]);
    return c;
  endfunction

  // Pick a byte of a word, big-endian order
  function automatic logic [7:0] word_byte(input logic [31:0] w,
                                           input logic [1:0]  i);
    logic [7:0] b;
    case (i)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pcf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_front: request classifier and chunk state
// Accepts requests, tracks the open chunk and running CRC, and pushes one
// job per request into the job queue.
// ----------------------------------------------------------------------------
module pcf_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [31:0]          in_chunk_type,
  input  wire logic [30:0]          in_chunk_length,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 q_full,
  output logic                      q_push,
  output pcf_pkg::job_t             q_job
);
  import pcf_pkg::*;

  logic [31:0]      crc_r, crc_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             open_r, open_nxt;
  logic [31:0]      hdr_crc;
  logic [31:0]      dat_crc;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign hdr_crc = crc_word(CRC_ONES, in_chunk_type);
  assign dat_crc = crc_byte(crc_r, in_data_byte);

  // Classify the request and advance the chunk state
  always_comb begin
    crc_nxt   = crc_r;
    left_nxt  = left_r;
    open_nxt  = open_r;
    q_job       = '0;
    q_job.kind  = JOB_ERR;
    q_job.err   = ERR_NONE;
    q_job.len   = in_chunk_length;
    q_job.ctype = in_chunk_type;
    q_job.data  = in_data_byte;
    if (accept) begin
      if (req_type_t'(in_req_type) == REQ_START) begin
        if (open_r) begin
          // Drop the start and abandon the open chunk
          q_job.kind = JOB_ERR;
          q_job.err  = ERR_ABANDON;
          crc_nxt    = CRC_ONES;
          left_nxt   = '0;
          open_nxt   = 1'b0;
        end else begin
          q_job.kind = JOB_HDR;
          q_job.fin  = (in_chunk_length == '0);
          q_job.crc  = hdr_crc ^ CRC_ONES;
          if (in_chunk_length == '0) begin
            crc_nxt  = CRC_ONES;
            left_nxt = '0;
            open_nxt = 1'b0;
          end else begin
            crc_nxt  = hdr_crc;
            left_nxt = in_chunk_length;
            open_nxt = 1'b1;
          end
        end
      end else begin
        if (!open_r) begin
          q_job.kind = JOB_ERR;
          q_job.err  = ERR_NO_CHUNK;
        end else begin
          q_job.kind = JOB_DATA;
          q_job.fin  = (left_r == LEN_W'(1));
          q_job.crc  = dat_crc ^ CRC_ONES;
          if (left_r == LEN_W'(1)) begin
            crc_nxt  = CRC_ONES;
            left_nxt = '0;
            open_nxt = 1'b0;
          end else begin
            crc_nxt  = dat_crc;
            left_nxt = left_r - LEN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_ONES;
      left_r <= '0;
      open_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pcf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_queue: short job queue between front and back
// Register-based FIFO; the head entry is visible to the back at all times.
// ----------------------------------------------------------------------------
module pcf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pcf_pkg::job_t  push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output pcf_pkg::job_t       head_job
);
  import pcf_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pcf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_back: byte sequencer
// Expands the job at the queue head into its result bytes, one per cycle
// while the registered output stage is free to take one (not stalled).
// ----------------------------------------------------------------------------
module pcf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire pcf_pkg::job_t  head_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic [2:0]          out_byte_kind,
  output logic                out_chunk_done,
  output logic                out_run_last,
  output logic [1:0]          out_error_code
);
  import pcf_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       byte_r;
  byte_kind_t       kind_r;
  logic             done_r, last_r;
  err_code_t        err_r;

  logic [7:0]       g_byte;
  byte_kind_t       g_kind;
  logic             g_last, g_done;
  err_code_t        g_err;
  logic             slot_free, fire;

  assign slot_free = !vld_r || out_ready;
  assign fire      = !q_empty && slot_free;
  assign q_pop     = fire && g_last;

  // Generate the byte at the current index of the head job
  always_comb begin
    g_byte = '0;
    g_kind = KIND_NONE;
    g_last = 1'b1;
    g_err  = ERR_NONE;
    case (head_job.kind)
      JOB_ERR: begin
        g_err = head_job.err;
      end
      JOB_HDR: begin
        if (idx_r < IDX_LEN_END) begin
          g_byte = word_byte({1'b0, head_job.len}, idx_r[1:0]);
          g_kind = KIND_LENGTH;
        end else if (idx_r < IDX_TYPE_END) begin
          g_byte = word_byte(head_job.ctype, idx_r[1:0]);
          g_kind = KIND_TYPE;
        end else begin
          g_byte = word_byte(head_job.crc, idx_r[1:0]);
          g_kind = KIND_CRC;
        end
        g_last = head_job.fin ? (idx_r == IDX_HDR_FIN) : (idx_r == IDX_HDR_LAST);
      end
      JOB_DATA: begin
        if (idx_r == '0) begin
          g_byte = head_job.data;
          g_kind = KIND_DATA;
        end else begin
          g_byte = word_byte(head_job.crc, idx_r[1:0] - 2'd1);
          g_kind = KIND_CRC;
        end
        g_last = head_job.fin ? (idx_r == IDX_DAT_FIN) : (idx_r == '0);
      end
      default: begin
        g_err = ERR_NONE;
      end
    endcase
    g_done = (g_kind == KIND_CRC) && g_last;
  end

  // Advance the index and hold the output stage while stalled
  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (fire) begin
      idx_nxt = g_last ? '0 : idx_r + 1'b1;
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= g_byte;
      kind_r <= g_kind;
      done_r <= g_done;
      last_r <= g_last;
      err_r  <= g_err;
    end
  end

  assign out_valid      = vld_r;
  assign out_byte       = byte_r;
  assign out_byte_kind  = kind_r;
  assign out_chunk_done = done_r;
  assign out_run_last   = last_r;
  assign out_error_code = err_r;

endmodule
`default_nettype wire

### hw/rtl/png_chunk_framer_crc32.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32: PNG chunk framer with CRC-32
// Turns start and data requests into the framed chunk byte stream.
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------
//   in_     | input     | in_valid/in_ready, req_type, chunk type/length, data
//   out_    | output    | out_valid/out_ready, byte, kind, done, last, error
//
// A request is taken every cycle while the four-entry job queue has room.
// The byte sequencer expands each job into its results: a data request gives
// one byte (five when it closes the chunk), a start gives eight or twelve,
// an error one. The sequencer sets the sustained rate at one result a cycle while out is not stalled.
// Reset clears the chunk state, the queue and the output stage.
// A stalled output holds its byte and backs up into the queue, then input.
// ----------------------------------------------------------------------------
module png_chunk_framer_crc32 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_chunk_type,
  input  wire logic [30:0] in_chunk_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_byte_kind,
  output logic             out_chunk_done,
  output logic             out_run_last,
  output logic [1:0]       out_error_code
);
  import pcf_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_full, q_pop, q_empty;

  pcf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_chunk_type   (in_chunk_type),
    .in_chunk_length (in_chunk_length),
    .in_data_byte    (in_data_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  pcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  pcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head_job       (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_kind  (out_byte_kind),
    .out_chunk_done (out_chunk_done),
    .out_run_last   (out_run_last),
    .out_error_code (out_error_code)
  );

endmodule
`default_nettype wire

### dv/pcf_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_stream_checker: result predictor and comparator for the chunk framer
// Watches both channels of png_chunk_framer_crc32. Each accepted request is
// run through a private model of the framer (chunk state plus CRC-32), and
// the framed bytes it yields are queued. Each accepted result is matched
// field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module pcf_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_chunk_type,
  input  logic [30:0] in_chunk_length,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [2:0]  out_byte_kind,
  input  logic        out_chunk_done,
  input  logic        out_run_last,
  input  logic [1:0]  out_error_code,
  output int          failures,
  output int          pending,
  output int          bytes_checked,
  output int          chunks_closed
);
  import pcf_pkg::*;

  typedef struct {
    logic [7:0] octet;
    byte_kind_t kind;
    logic       done;
    logic       last;
    err_code_t  err;
  } framed_byte_t;

  // Expected framed stream, oldest first
  framed_byte_t framed_q[$];

  // Model copy of the chunk state
  logic [31:0] crc_acc;
  logic [30:0] data_left;
  logic        in_chunk;

  initial begin
    failures      = 0;
    pending       = 0;
    bytes_checked = 0;
    chunks_closed = 0;
  end

  // Reflected CRC-32, shift one bit at a time through the byte
  function automatic logic [31:0] crc32_update(input logic [31:0] crc,
                                               input logic [7:0]  octet);
    logic [31:0] c;
    c = crc ^ {24'd0, octet};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] octet, input byte_kind_t kind,
                           input err_code_t err);
    framed_byte_t fb;
    fb.octet = octet;
    fb.kind  = kind;
    fb.done  = 1'b0;
    fb.last  = 1'b0;
    fb.err   = err;
    framed_q.push_back(fb);
  endtask

  // Queue a word as four bytes, most significant first
  task automatic push_word(input logic [31:0] w, input byte_kind_t kind);
    for (int i = 3; i >= 0; i--) begin
      push_byte(w[8*i +: 8], kind, ERR_NONE);
    end
  endtask

  // Emit the inverted CRC and close the chunk
  task automatic close_chunk();
    push_word(~crc_acc, KIND_CRC);
    framed_q[framed_q.size()-1].done = 1'b1;
    crc_acc   = CRC_ONES;
    data_left = '0;
    in_chunk  = 1'b0;
    chunks_closed++;
  endtask

  // Advance the model by one request and queue the bytes it frames
  task automatic frame_request(input req_type_t req, input logic [31:0] ctype,
                               input logic [30:0] clen, input logic [7:0] dbyte);
    if (req == REQ_START) begin
      if (in_chunk) begin
        // abandon the open chunk, drop the new start
        crc_acc   = CRC_ONES;
        data_left = '0;
        in_chunk  = 1'b0;
        push_byte(8'd0, KIND_NONE, ERR_ABANDON);
      end else begin
        push_word({1'b0, clen}, KIND_LENGTH);
        push_word(ctype, KIND_TYPE);
        crc_acc = CRC_ONES;
        for (int i = 3; i >= 0; i--) begin
          crc_acc = crc32_update(crc_acc, ctype[8*i +: 8]);
        end
        if (clen == '0) begin
          close_chunk();
        end else begin
          data_left = clen;
          in_chunk  = 1'b1;
        end
      end
    end else begin
      if (!in_chunk) begin
        push_byte(8'd0, KIND_NONE, ERR_NO_CHUNK);
      end else begin
        push_byte(dbyte, KIND_DATA, ERR_NONE);
        crc_acc   = crc32_update(crc_acc, dbyte);
        data_left = data_left - 31'd1;
        if (data_left == '0) close_chunk();
      end
    end
    framed_q[framed_q.size()-1].last = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Check results first: a result never comes from a request taken this edge
  always @(posedge clk) begin
    framed_byte_t fb;
    if (!rst_n) begin
      framed_q.delete();
      crc_acc   = CRC_ONES;
      data_left = '0;
      in_chunk  = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected result: byte 0x%0h kind %0d error %0d",
                 out_byte, out_byte_kind, out_error_code);
          failures++;
        end else begin
          fb = framed_q.pop_front();
          compare_field("out_byte", fb.octet, out_byte);
          compare_field("out_byte_kind", fb.kind, out_byte_kind);
          compare_field("out_chunk_done", fb.done, out_chunk_done);
          compare_field("out_run_last", fb.last, out_run_last);
          compare_field("out_error_code", fb.err, out_error_code);
          bytes_checked++;
        end
      end
      if (in_valid && in_ready) begin
        frame_request(req_type_t'(in_req_type), in_chunk_type, in_chunk_length,
                      in_data_byte);
      end
    end
    pending = framed_q.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for png_chunk_framer_crc32
// Drives start and data requests (directed corner cases, then random chunks,
// stray bytes and abandoned chunks) under four idle/stall mixes, and gives
// the verdict from the checker's failure count and leftover expectations.
// ----------------------------------------------------------------------------
module testbench;
  import pcf_pkg::*;

  localparam int ITEM_TARGET = 170;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [31:0] in_chunk_type;
  logic [30:0] in_chunk_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [2:0]  out_byte_kind;
  logic        out_chunk_done;
  logic        out_run_last;
  logic [1:0]  out_error_code;

  int failures;
  int pending;
  int bytes_checked;
  int chunks_closed;

  int idle_pct;
  int stall_pct;
  int n_items;
  int n_starts;
  int n_data;
  int quiet_cycles;

  png_chunk_framer_crc32 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_chunk_type   (in_chunk_type),
    .in_chunk_length (in_chunk_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_kind   (out_byte_kind),
    .out_chunk_done  (out_chunk_done),
    .out_run_last    (out_run_last),
    .out_error_code  (out_error_code)
  );

  pcf_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_chunk_type   (in_chunk_type),
    .in_chunk_length (in_chunk_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_kind   (out_byte_kind),
    .out_chunk_done  (out_chunk_done),
    .out_run_last    (out_run_last),
    .out_error_code  (out_error_code),
    .failures        (failures),
    .pending         (pending),
    .bytes_checked   (bytes_checked),
    .chunks_closed   (chunks_closed)
  );

  // Clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Abort if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("png_chunk_framer_crc32 verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted
  task automatic send(input req_type_t req, input logic [31:0] ctype,
                      input logic [30:0] clen, input logic [7:0] dbyte);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_chunk_type   <= ctype;
    in_chunk_length <= clen;
    in_data_byte    <= dbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  // Start request; the unused data byte is random
  task automatic send_start(input logic [31:0] ctype, input logic [30:0] clen);
    send(REQ_START, ctype, clen, 8'($urandom));
    n_starts++;
  endtask

  // Data request; the unused type and length are random
  task automatic send_data(input logic [7:0] dbyte);
    send(REQ_DATA, $urandom, 31'($urandom), dbyte);
    n_data++;
  endtask

  // Hold off the sender until every expected result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          target;
    logic [30:0] clen;

    in_valid        <= 1'b0;
    in_req_type     <= REQ_START;
    in_chunk_type   <= '0;
    in_chunk_length <= '0;
    in_data_byte    <= '0;
    out_ready       <= 1'b0;
    rst_n           <= 1'b0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    n_items         = 0;
    n_starts        = 0;
    n_data          = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stray byte, empty chunk, one- and two-byte chunks
    send_data(8'hFF);
    send_start(TYPE_IEND, 31'd0);
    send_start(32'hFFFF_FFFF, 31'd1);
    send_data(8'h00);
    send_start(32'h0000_0000, 31'd2);
    send_data(8'hFF);
    send_data(8'hA5);
    // Largest length, cut short by a second start, then a stray byte
    send_start(TYPE_IHDR, 31'h7FFF_FFFF);
    send_data(8'h5A);
    send_start(TYPE_IDAT, 31'd4);
    send_data(8'h3C);
    // Start right after start: header only, then abandoned
    send_start(TYPE_IDAT, 31'h4000_0000);
    send_start(TYPE_IEND, 31'd0);
    send_start(TYPE_IDAT, 31'd3);
    send_data(8'h01);
    send_data(8'h80);
    send_data(8'h7F);
    wait_drained();

    // Random: four idle/stall mixes, draining between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      target = (ITEM_TARGET * (phase + 1)) / 4;
      while (n_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          // well-formed chunk, mostly short
          clen = ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom_range(1, 8));
          send_start($urandom, clen);
          repeat (clen) send_data(8'($urandom));
        end else if (pick < 90) begin
          // open a chunk of any length, then break it with a start
          send_start($urandom, 31'($urandom_range(1, 32'h7FFF_FFFF)));
          repeat ($urandom_range(0, 3)) send_data(8'($urandom));
          send_start($urandom, 31'($urandom));
        end else begin
          // byte outside any chunk
          send_data(8'($urandom));
        end
      end
      wait_drained();
    end

    // Let any late result show up before the verdict
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end

    $display("Sent %0d requests (%0d starts, %0d data) over four idle/stall mixes.",
             n_items, n_starts, n_data);
    $display("Compared %0d framed bytes; %0d chunks closed with CRC.",
             bytes_checked, chunks_closed);
    if (failures == 0 && pending == 0) begin
      $display("png_chunk_framer_crc32 verification clean");
    end else begin
      $display("png_chunk_framer_crc32 verification failed");
    end
    $finish;
  end

endmodule

### png_chunk_framer_crc32.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_front.sv
hw/rtl/pcf_queue.sv
hw/rtl/pcf_back.sv
hw/rtl/png_chunk_framer_crc32.sv
dv/pcf_stream_checker.sv
dv/testbench.sv
